/* rtl/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int SIZE_W        = 14;
   localparam int NEAR_W        = 31;
   localparam int CSR_IDX_W     = 2;

   localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_NEAR_LIMIT    = 2'd2
   } csr_idx_type;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   typedef struct packed {
      logic vis;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

/* rtl/wsp_divpipe.sv */
// ----------------------------------------------------------------------------
// wsp_divpipe
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one denominator, with side information carried alongside.
// ----------------------------------------------------------------------------
module wsp_divpipe
   import wsp_pkg::*;
#(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num_a,
   input  logic [NUM_W-1:0] num_b,
   input  logic [DEN_W-1:0] den,
   input  side_type         side_in,
   output logic             out_valid,
   output logic [NUM_W-1:0] quo_a,
   output logic [NUM_W-1:0] quo_b,
   output side_type         side_out
);

   localparam int X_W = DEN_W + NUM_W;

   function automatic logic [X_W-1:0] div_step(input logic [X_W-1:0] x,
                                               input logic [DEN_W-1:0] d);
      logic [X_W:0]     t;
      logic [DEN_W:0]   hi;
      logic [DEN_W:0]   diff;
      logic [X_W-1:0]   r;
      t    = {x, 1'b0};
      hi   = t[X_W:NUM_W];
      diff = hi - {1'b0, d};
      if (!diff[DEN_W]) begin
         r = {diff[DEN_W-1:0], t[NUM_W-1:1], 1'b1};
      end else begin
         r = {hi[DEN_W-1:0], t[NUM_W-1:1], 1'b0};
      end
      return r;
   endfunction

   logic [X_W-1:0]   xa_ff [NUM_W];
   logic [X_W-1:0]   xb_ff [NUM_W];
   logic [DEN_W-1:0] d_ff  [NUM_W-1];
   side_type         s_ff  [NUM_W];
   logic             v_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [X_W-1:0]   xa_src;
      logic [X_W-1:0]   xb_src;
      logic [DEN_W-1:0] d_src;
      side_type         s_src;
      logic             v_src;

      if (k == 0) begin : g_head
         assign xa_src = {{DEN_W{1'b0}}, num_a};
         assign xb_src = {{DEN_W{1'b0}}, num_b};
         assign d_src  = den;
         assign s_src  = side_in;
         assign v_src  = in_valid;
      end else begin : g_tail
         assign xa_src = xa_ff[k-1];
         assign xb_src = xb_ff[k-1];
         assign d_src  = d_ff[k-1];
         assign s_src  = s_ff[k-1];
         assign v_src  = v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            xa_ff[k] <= div_step(xa_src, d_src);
            xb_ff[k] <= div_step(xb_src, d_src);
            s_ff[k]  <= s_src;
         end
      end
      if (k < NUM_W - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k] <= d_src;
            end
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quo_a     = xa_ff[NUM_W-1][NUM_W-1:0];
   assign quo_b     = xb_ff[NUM_W-1][NUM_W-1:0];
   assign side_out  = s_ff[NUM_W-1];

endmodule

/* rtl/world_to_screen_projection_top.sv */
// Throughput: one beat per cycle while the result beat is not stalled; the divider
// stages advance together with the output.
// Matrix loads take one beat and give no result.
// Reset (synchronous, active high) clears the matrix, empties the pipeline and
// restores width 1920, height 1080 and near limit 0.1.
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Perspective projection of world points through a loadable 4x4 matrix.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top
   import wsp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // matrix_index[3:0], matrix_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100]
   input  logic [135:0]          req_tdata,
   // mode[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // screen_x[31:0], screen_y[63:32]
   output logic [63:0]           rsp_tdata,
   // visible[0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [NEAR_W-1:0]     csr_data
);

   localparam int NUM_W  = DATA_W + FRAC_BITS;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int FIN_W  = DATA_W + SIZE_W + FRAC_BITS + 2;
   localparam longint unsigned NEAR_RST_L = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [NEAR_W-1:0] NEAR_RST = NEAR_W'(NEAR_RST_L);
   localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic adv;
   logic req_acc;
   logic [3:0] m_idx;
   logic signed [DATA_W-1:0] m_val, px, py, pz;

   assign m_idx = req_tdata[3:0];
   assign m_val = req_tdata[35:4];
   assign px    = req_tdata[67:36];
   assign py    = req_tdata[99:68];
   assign pz    = req_tdata[131:100];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign req_acc    = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [NEAR_W-1:0] near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         near_ff   <= NEAR_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_data[SIZE_W-1:0];
            CSR_NEAR_LIMIT:    near_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic signed [DATA_W-1:0] mat_ff [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
      end else if (req_acc && req_tuser == MODE_LOAD) begin
         mat_ff[m_idx] <= m_val;
      end
   end

   // stage 1: products
   logic v1_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [DATA_W-1:0] tr_ff [3];
   localparam int COL [3] = '{0, 1, 3};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_acc && req_tuser == MODE_PROJECT;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff[r][0] <= PROD_W'(px) * PROD_W'(mat_ff[COL[r]]);
            prod_ff[r][1] <= PROD_W'(pz) * PROD_W'(mat_ff[4 + COL[r]]);
            prod_ff[r][2] <= PROD_W'(py) * PROD_W'(mat_ff[8 + COL[r]]);
            tr_ff[r]      <= mat_ff[12 + COL[r]];
         end
      end
   end

   // stage 2: clip sums
   logic v2_ff;
   logic signed [DATA_W-1:0] clip_ff [3];
   logic signed [DATA_W-1:0] clip_in [3];

   always_comb begin
      logic signed [SUM_W-1:0] s;
      for (int r = 0; r < 3; r++) begin
         s = SUM_W'(prod_ff[r][0] >>> FRAC_BITS) + SUM_W'(prod_ff[r][1] >>> FRAC_BITS)
           + SUM_W'(prod_ff[r][2] >>> FRAC_BITS) + SUM_W'(tr_ff[r]);
         if (s > SUM_W'(SMAX)) begin
            clip_in[r] = SMAX;
         end else if (s < SUM_W'(SMIN)) begin
            clip_in[r] = SMIN;
         end else begin
            clip_in[r] = s[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         clip_ff <= clip_in;
      end
   end

   // stage 3: visibility and magnitudes
   logic v3_ff;
   logic [DATA_W-1:0] mag_x_ff, mag_y_ff;
   logic [DATA_W-2:0] den_ff;
   side_type side3_ff;
   logic [DATA_W-1:0] cw_u;

   assign cw_u = clip_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_x_ff <= clip_ff[0][DATA_W-1] ? DATA_W'(-clip_ff[0]) : clip_ff[0];
         mag_y_ff <= clip_ff[1][DATA_W-1] ? DATA_W'(-clip_ff[1]) : clip_ff[1];
         den_ff   <= cw_u[DATA_W-2:0];
         side3_ff.vis   <= !cw_u[DATA_W-1] && cw_u != '0 && cw_u[DATA_W-2:0] >= near_ff;
         side3_ff.neg_x <= clip_ff[0][DATA_W-1];
         side3_ff.neg_y <= clip_ff[1][DATA_W-1];
      end
   end

   // divider
   logic vd;
   logic [NUM_W-1:0] qa, qb;
   side_type sided;

   wsp_divpipe #(.NUM_W(NUM_W), .DEN_W(DATA_W - 1)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .num_a     ({mag_x_ff, {FRAC_BITS{1'b0}}}),
      .num_b     ({mag_y_ff, {FRAC_BITS{1'b0}}}),
      .den       (den_ff),
      .side_in   (side3_ff),
      .out_valid (vd),
      .quo_a     (qa),
      .quo_b     (qb),
      .side_out  (sided)
   );

   // stage 4: saturate ndc and scale by half sizes
   function automatic logic signed [DATA_W-1:0] sat_ndc(input logic [NUM_W-1:0] q,
                                                        input logic neg);
      logic signed [DATA_W-1:0] r;
      if (neg) begin
         r = (q > {{(NUM_W-DATA_W){1'b0}}, SMIN}) ? SMIN : DATA_W'(-q);
      end else begin
         r = (q > NUM_W'(SMAX)) ? SMAX : q[DATA_W-1:0];
      end
      return r;
   endfunction

   logic v4_ff, vis4_ff;
   logic signed [DATA_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [FIN_W-1:0] px4_ff, py4_ff;
   logic signed [SIZE_W:0] hw, hh;

   assign hw    = {2'b00, width_ff[SIZE_W-1:1]};
   assign hh    = {2'b00, height_ff[SIZE_W-1:1]};
   assign nx_in = sat_ndc(qa, sided.neg_x);
   assign ny_in = sat_ndc(qb, sided.neg_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= vd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis4_ff <= sided.vis;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         px4_ff  <= FIN_W'(nx_in) * FIN_W'(hw);
         py4_ff  <= FIN_W'(ny_in) * FIN_W'(hh);
      end
   end

   // stage 5: screen sums into the output register
   logic signed [FIN_W-1:0] sx_w, sy_w;
   logic signed [DATA_W-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic vo_ff, viso_ff;

   assign sx_w = px4_ff + FIN_W'(nx_ff) + (FIN_W'(hw) <<< FRAC_BITS);
   assign sy_w = -py4_ff + FIN_W'(ny_ff) + (FIN_W'(hh) <<< FRAC_BITS);

   always_comb begin
      if (!vis4_ff) begin
         sx_in = '0;
      end else if (sx_w > FIN_W'(SMAX)) begin
         sx_in = SMAX;
      end else if (sx_w < FIN_W'(SMIN)) begin
         sx_in = SMIN;
      end else begin
         sx_in = sx_w[DATA_W-1:0];
      end
      if (!vis4_ff) begin
         sy_in = '0;
      end else if (sy_w > FIN_W'(SMAX)) begin
         sy_in = SMAX;
      end else if (sy_w < FIN_W'(SMIN)) begin
         sy_in = SMIN;
      end else begin
         sy_in = sy_w[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         viso_ff <= vis4_ff;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tuser  = viso_ff;
   assign rsp_tdata  = {sy_ff, sx_ff};

endmodule

/* rtl/wsp_checker.sv */
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module wsp_checker
   import wsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat after reset");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tdata == 64'd0)
      else $error("hidden point with nonzero screen position");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind world_to_screen_projection_top wsp_checker u_wsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
